// ===== hw/rtl/iebm_pkg.sv =====
// Shared types and constants for the I2C EEPROM byte master.
package iebm_pkg;

    // Payload of one tick offered to the bus engine.
    typedef struct packed {
        logic       req_valid;
        logic       req_type;
        logic [7:0] mem_address;
        logic [7:0] write_data;
        logic       sda_in;
    } iebm_req_t;

    // Payload of one tick reported by the bus engine.
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_driving;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       ack_error;
    } iebm_res_t;

    // Queue status seen by the top level.
    typedef struct packed {
        logic full;
        logic empty;
    } iebm_queue_status_t;

    localparam int CfgIndexW = 2;
    localparam int CfgDataW  = 16;

    // Configuration register indexes.
    localparam logic [CfgIndexW-1:0] CFG_TICKS_PER_US  = 2'd0;
    localparam logic [CfgIndexW-1:0] CFG_DEVICE_ADDR   = 2'd1;
    localparam logic [CfgIndexW-1:0] CFG_ACK_POLL_LIM  = 2'd2;
    localparam logic [CfgIndexW-1:0] CFG_WRITE_WAIT_US = 2'd3;

    // Configuration reset values.
    localparam logic [7:0]  TICKS_PER_US_RESET  = 8'd72;
    localparam logic [6:0]  DEVICE_ADDR_RESET   = 7'd80;
    localparam logic [7:0]  ACK_POLL_LIM_RESET  = 8'd250;
    localparam logic [15:0] WRITE_WAIT_US_RESET = 16'd10000;

    // Bus timing in microsecond units.
    localparam logic [15:0] UNITS_ONE  = 16'd1;
    localparam logic [15:0] UNITS_TWO  = 16'd2;
    localparam logic [15:0] UNITS_FOUR = 16'd4;

endpackage

// ===== hw/rtl/iebm_if.sv =====
// Handshake interfaces for the request, result and configuration channels.
interface iebm_req_if;
    logic                valid;
    logic                ready;
    iebm_pkg::iebm_req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface iebm_res_if;
    logic                valid;
    logic                ready;
    iebm_pkg::iebm_res_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface iebm_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [iebm_pkg::CfgIndexW-1:0]     index;
    logic [iebm_pkg::CfgDataW-1:0]      data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/iebm_engine.sv =====
// Front part: tick engine that runs the bus sequencer one tick per transaction.
module iebm_engine #(
    parameter int DELAY_COUNT_WIDTH = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    iebm_cfg_if.sink            cfg,
    input  logic                step,
    input  iebm_pkg::iebm_req_t req_data,
    output iebm_pkg::iebm_res_t res_data
);
    import iebm_pkg::*;

    localparam int DW    = DELAY_COUNT_WIDTH;
    localparam int ProdW = 24;
    localparam int CmpW  = (DW > ProdW) ? DW : ProdW;

    // Sequencer phase codes.
    localparam logic [4:0] PH_IDLE       = 5'd0;
    localparam logic [4:0] PH_START_A    = 5'd1;
    localparam logic [4:0] PH_START_B    = 5'd2;
    localparam logic [4:0] PH_TX_LOW     = 5'd3;
    localparam logic [4:0] PH_TX_HIGH    = 5'd4;
    localparam logic [4:0] PH_TX_TAIL    = 5'd5;
    localparam logic [4:0] PH_ACK_SETUP  = 5'd6;
    localparam logic [4:0] PH_ACK_RISE   = 5'd7;
    localparam logic [4:0] PH_ACK_POLL   = 5'd8;
    localparam logic [4:0] PH_RX_LOW     = 5'd9;
    localparam logic [4:0] PH_RX_HIGH    = 5'd10;
    localparam logic [4:0] PH_RX_HOLD    = 5'd11;
    localparam logic [4:0] PH_NACK_LOW   = 5'd12;
    localparam logic [4:0] PH_NACK_HIGH  = 5'd13;
    localparam logic [4:0] PH_STOP_A     = 5'd14;
    localparam logic [4:0] PH_STOP_B     = 5'd15;
    localparam logic [4:0] PH_WRITE_WAIT = 5'd16;
    localparam logic [4:0] PH_DONE       = 5'd17;

    // Byte stage codes.
    localparam logic [1:0] STG_DEV_WR  = 2'd0;
    localparam logic [1:0] STG_MEM_ADR = 2'd1;
    localparam logic [1:0] STG_DATA    = 2'd2;
    localparam logic [1:0] STG_DEV_RD  = 2'd3;

    logic [7:0]    tpm_reg;
    logic [6:0]    dev_reg;
    logic [7:0]    poll_lim_reg;
    logic [15:0]   wwait_reg;

    logic [4:0]    phase_reg, phase_next;
    logic [3:0]    bit_count_reg, bit_count_next;
    logic [DW-1:0] delay_count_reg, delay_count_next;
    logic [7:0]    poll_count_reg, poll_count_next;
    logic [7:0]    tx_shift_reg, tx_shift_next;
    logic [7:0]    rx_shift_reg, rx_shift_next;
    logic [7:0]    held_address_reg, held_address_next;
    logic [7:0]    held_data_reg, held_data_next;
    logic          held_is_read_reg, held_is_read_next;
    logic          error_flag_reg, error_flag_next;
    logic [1:0]    byte_stage_reg, byte_stage_next;

    logic          do_enter;
    logic [4:0]    enter_phase;
    logic [15:0]   enter_units;
    logic [ProdW-1:0] prod;
    logic [CmpW-1:0]  prod_ext;
    logic [CmpW-1:0]  max_ext;
    logic [DW-1:0]    enter_delay;
    logic [3:0]       bit_inc;

    assign cfg.ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpm_reg      <= TICKS_PER_US_RESET;
            dev_reg      <= DEVICE_ADDR_RESET;
            poll_lim_reg <= ACK_POLL_LIM_RESET;
            wwait_reg    <= WRITE_WAIT_US_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_TICKS_PER_US:  tpm_reg      <= cfg.data[7:0];
                CFG_DEVICE_ADDR:   dev_reg      <= cfg.data[6:0];
                CFG_ACK_POLL_LIM:  poll_lim_reg <= cfg.data[7:0];
                CFG_WRITE_WAIT_US: wwait_reg    <= cfg.data;
                default:           wwait_reg    <= wwait_reg;
            endcase
        end
    end

    // Phase length in ticks, saturated to the delay counter.
    assign prod        = ProdW'(enter_units) * ProdW'(tpm_reg);
    assign prod_ext    = CmpW'(prod);
    assign max_ext     = CmpW'({DW{1'b1}});
    assign enter_delay = (prod_ext > max_ext) ? {DW{1'b1}} : prod_ext[DW-1:0];
    assign bit_inc     = bit_count_reg + 4'd1;

    // Line levels driven during the current tick.
    always_comb
    begin
        res_data             = '0;
        res_data.scl_level   = 1'b1;
        res_data.sda_level   = 1'b1;
        res_data.sda_driving = 1'b1;
        res_data.busy_res    = 1'b1;
        res_data.done_res    = 1'b0;
        res_data.read_byte   = rx_shift_reg;
        res_data.ack_error   = error_flag_reg;
        unique case (phase_reg)
            PH_IDLE:
                res_data.busy_res = 1'b0;
            PH_START_B:
                res_data.sda_level = 1'b0;
            PH_TX_LOW, PH_TX_TAIL:
            begin
                res_data.scl_level = 1'b0;
                res_data.sda_level = tx_shift_reg[7];
            end
            PH_TX_HIGH:
                res_data.sda_level = tx_shift_reg[7];
            PH_ACK_SETUP, PH_RX_LOW:
            begin
                res_data.scl_level   = 1'b0;
                res_data.sda_driving = 1'b0;
            end
            PH_ACK_RISE, PH_ACK_POLL, PH_RX_HIGH, PH_RX_HOLD:
                res_data.sda_driving = 1'b0;
            PH_NACK_LOW:
                res_data.scl_level = 1'b0;
            PH_STOP_A:
            begin
                res_data.scl_level = 1'b0;
                res_data.sda_level = 1'b0;
            end
            PH_DONE:
            begin
                res_data.busy_res = 1'b0;
                res_data.done_res = 1'b1;
            end
            default:
                res_data.busy_res = 1'b1;
        endcase
    end

    // Sequencer next state for an accepted tick.
    always_comb
    begin
        phase_next        = phase_reg;
        bit_count_next    = bit_count_reg;
        delay_count_next  = delay_count_reg;
        poll_count_next   = poll_count_reg;
        tx_shift_next     = tx_shift_reg;
        rx_shift_next     = rx_shift_reg;
        held_address_next = held_address_reg;
        held_data_next    = held_data_reg;
        held_is_read_next = held_is_read_reg;
        error_flag_next   = error_flag_reg;
        byte_stage_next   = byte_stage_reg;
        do_enter          = 1'b0;
        enter_phase       = PH_IDLE;
        enter_units       = UNITS_ONE;

        if (step)
        begin
            if (phase_reg == PH_IDLE)
            begin
                // Take a new request only while idle.
                if (req_data.req_valid)
                begin
                    held_is_read_next = req_data.req_type;
                    held_address_next = req_data.mem_address;
                    held_data_next    = req_data.write_data;
                    error_flag_next   = 1'b0;
                    if (req_data.req_type)
                    begin
                        rx_shift_next = 8'd0;
                    end
                    byte_stage_next = STG_DEV_WR;
                    tx_shift_next   = {dev_reg, 1'b0};
                    do_enter        = 1'b1;
                    enter_phase     = PH_START_A;
                    enter_units     = UNITS_FOUR;
                end
            end
            else if (phase_reg == PH_DONE)
            begin
                phase_next       = PH_IDLE;
                delay_count_next = '0;
            end
            else if (phase_reg == PH_ACK_POLL)
            begin
                // Acknowledge seen: move on to the next byte or step.
                if (!req_data.sda_in)
                begin
                    if (byte_stage_reg == STG_DEV_WR)
                    begin
                        byte_stage_next = STG_MEM_ADR;
                        tx_shift_next   = held_address_reg;
                        bit_count_next  = 4'd0;
                        do_enter        = 1'b1;
                        enter_phase     = PH_TX_LOW;
                        enter_units     = UNITS_TWO;
                    end
                    else if (byte_stage_reg == STG_MEM_ADR && !held_is_read_reg)
                    begin
                        byte_stage_next = STG_DATA;
                        tx_shift_next   = held_data_reg;
                        bit_count_next  = 4'd0;
                        do_enter        = 1'b1;
                        enter_phase     = PH_TX_LOW;
                        enter_units     = UNITS_TWO;
                    end
                    else if (byte_stage_reg == STG_MEM_ADR)
                    begin
                        byte_stage_next = STG_DEV_RD;
                        tx_shift_next   = {dev_reg, 1'b1};
                        do_enter        = 1'b1;
                        enter_phase     = PH_START_A;
                        enter_units     = UNITS_FOUR;
                    end
                    else if (byte_stage_reg == STG_DEV_RD)
                    begin
                        bit_count_next = 4'd0;
                        do_enter       = 1'b1;
                        enter_phase    = PH_RX_LOW;
                        enter_units    = UNITS_TWO;
                    end
                    else
                    begin
                        do_enter    = 1'b1;
                        enter_phase = PH_STOP_A;
                        enter_units = UNITS_FOUR;
                    end
                end
                else if (poll_count_reg >= poll_lim_reg)
                begin
                    error_flag_next = 1'b1;
                    do_enter        = 1'b1;
                    enter_phase     = PH_STOP_A;
                    enter_units     = UNITS_FOUR;
                end
                else
                begin
                    poll_count_next = poll_count_reg + 8'd1;
                end
            end
            else if (phase_reg > PH_DONE)
            begin
                phase_next       = PH_IDLE;
                delay_count_next = '0;
            end
            else if (delay_count_reg > DW'(1))
            begin
                delay_count_next = delay_count_reg - DW'(1);
            end
            else
            begin
                // End of a timed phase.
                unique case (phase_reg)
                    PH_START_A:
                    begin
                        do_enter    = 1'b1;
                        enter_phase = PH_START_B;
                        enter_units = UNITS_FOUR;
                    end
                    PH_START_B:
                    begin
                        bit_count_next = 4'd0;
                        do_enter       = 1'b1;
                        enter_phase    = PH_TX_LOW;
                        enter_units    = UNITS_TWO;
                    end
                    PH_TX_LOW:
                    begin
                        do_enter    = 1'b1;
                        enter_phase = PH_TX_HIGH;
                        enter_units = UNITS_TWO;
                    end
                    PH_TX_HIGH:
                    begin
                        do_enter    = 1'b1;
                        enter_phase = PH_TX_TAIL;
                        enter_units = UNITS_TWO;
                    end
                    PH_TX_TAIL:
                    begin
                        tx_shift_next  = {tx_shift_reg[6:0], 1'b0};
                        bit_count_next = bit_inc;
                        do_enter       = 1'b1;
                        if (bit_inc >= 4'd8)
                        begin
                            poll_count_next = 8'd0;
                            enter_phase     = PH_ACK_SETUP;
                            enter_units     = UNITS_ONE;
                        end
                        else
                        begin
                            enter_phase = PH_TX_LOW;
                            enter_units = UNITS_TWO;
                        end
                    end
                    PH_ACK_SETUP:
                    begin
                        do_enter    = 1'b1;
                        enter_phase = PH_ACK_RISE;
                        enter_units = UNITS_ONE;
                    end
                    PH_ACK_RISE:
                    begin
                        phase_next       = PH_ACK_POLL;
                        delay_count_next = '0;
                    end
                    PH_RX_LOW:
                    begin
                        do_enter    = 1'b1;
                        enter_phase = PH_RX_HIGH;
                        enter_units = UNITS_TWO;
                    end
                    PH_RX_HIGH:
                    begin
                        rx_shift_next = {rx_shift_reg[6:0], req_data.sda_in};
                        do_enter      = 1'b1;
                        enter_phase   = PH_RX_HOLD;
                        enter_units   = UNITS_ONE;
                    end
                    PH_RX_HOLD:
                    begin
                        bit_count_next = bit_inc;
                        do_enter       = 1'b1;
                        enter_units    = UNITS_TWO;
                        enter_phase    = (bit_inc >= 4'd8) ? PH_NACK_LOW : PH_RX_LOW;
                    end
                    PH_NACK_LOW:
                    begin
                        do_enter    = 1'b1;
                        enter_phase = PH_NACK_HIGH;
                        enter_units = UNITS_TWO;
                    end
                    PH_NACK_HIGH:
                    begin
                        do_enter    = 1'b1;
                        enter_phase = PH_STOP_A;
                        enter_units = UNITS_FOUR;
                    end
                    PH_STOP_A:
                    begin
                        do_enter    = 1'b1;
                        enter_phase = PH_STOP_B;
                        enter_units = UNITS_FOUR;
                    end
                    PH_STOP_B:
                    begin
                        // A clean write waits out the device's internal write cycle.
                        if (!held_is_read_reg && !error_flag_reg)
                        begin
                            do_enter    = 1'b1;
                            enter_phase = PH_WRITE_WAIT;
                            enter_units = wwait_reg;
                        end
                        else
                        begin
                            phase_next       = PH_DONE;
                            delay_count_next = '0;
                        end
                    end
                    PH_WRITE_WAIT:
                    begin
                        phase_next       = PH_DONE;
                        delay_count_next = '0;
                    end
                    default:
                    begin
                        phase_next       = PH_IDLE;
                        delay_count_next = '0;
                    end
                endcase
            end

            if (do_enter)
            begin
                phase_next       = enter_phase;
                delay_count_next = enter_delay;
            end
        end
    end

    // Sequencer state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            bit_count_reg    <= '0;
            delay_count_reg  <= '0;
            poll_count_reg   <= '0;
            tx_shift_reg     <= '0;
            rx_shift_reg     <= '0;
            held_address_reg <= '0;
            held_data_reg    <= '0;
            held_is_read_reg <= 1'b0;
            error_flag_reg   <= 1'b0;
            byte_stage_reg   <= STG_DEV_WR;
        end
        else
        begin
            phase_reg        <= phase_next;
            bit_count_reg    <= bit_count_next;
            delay_count_reg  <= delay_count_next;
            poll_count_reg   <= poll_count_next;
            tx_shift_reg     <= tx_shift_next;
            rx_shift_reg     <= rx_shift_next;
            held_address_reg <= held_address_next;
            held_data_reg    <= held_data_next;
            held_is_read_reg <= held_is_read_next;
            error_flag_reg   <= error_flag_next;
            byte_stage_reg   <= byte_stage_next;
        end
    end

endmodule

// ===== hw/rtl/iebm_queue.sv =====
// Back part: two-entry result queue that feeds the result channel.
module iebm_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  iebm_pkg::iebm_res_t          push_data,
    output iebm_pkg::iebm_queue_status_t status,
    iebm_res_if.source                   res
);
    import iebm_pkg::*;

    iebm_res_t  entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign res.valid    = !status.empty;
    assign res.data     = entry_reg[rd_ptr_reg];
    assign pop          = res.valid && res.ready;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/i2c_eeprom_byte_master_core.sv =====
// Top level of the tick-driven I2C EEPROM byte master.
//
//  Channel  Role    Transaction carries
//  -------  ------  ------------------------------------------------------
//  cfg      sink    register index and write data, always ready
//  req      sink    one bus tick: request fields and sampled SDA level
//  res      source  one bus tick: SCL/SDA levels, busy, done, read byte, error
//
// Each req transaction is one bus tick and gives exactly one res transaction.
// The tick engine takes one transaction per cycle; its result enters a two-entry
// queue and is offered on res in the next cycle, so the rate is one per cycle.
// req stalls only while the queue holds two unclaimed results.
// Reset returns the bus to idle and loads the register reset values.
module i2c_eeprom_byte_master_core #(
    parameter int DELAY_COUNT_WIDTH = 24
) (
    input  logic       clk,
    input  logic       rst_n,
    iebm_cfg_if.sink   cfg,
    iebm_req_if.sink   req,
    iebm_res_if.source res
);
    import iebm_pkg::*;

    iebm_res_t          tick_res;
    iebm_queue_status_t q_status;
    logic               step;

    // Accept a tick whenever the queue has room.
    assign req.ready = !q_status.full;
    assign step      = req.valid && req.ready;

    iebm_engine #(
        .DELAY_COUNT_WIDTH(DELAY_COUNT_WIDTH)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .step     (step),
        .req_data (req.data),
        .res_data (tick_res)
    );

    iebm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .push_data (tick_res),
        .status    (q_status),
        .res       (res)
    );

    // An accepted tick always leaves a result to offer in the next cycle.
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> res.valid)
        else $error("accepted tick left no result");

    // With nothing queued the block must take ticks.
    a_empty_means_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !res.valid |-> req.ready)
        else $error("empty queue but request channel stalled");

    // The done tick is never reported as busy.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !(res.data.done_res && res.data.busy_res))
        else $error("done and busy reported together");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the tick-driven I2C EEPROM byte master.
`timescale 1ns / 1ps

module testbench;
    import iebm_pkg::*;

    localparam int          DELAY_W     = 24;
    localparam logic [31:0] DELAY_MAX   = (32'd1 << DELAY_W) - 32'd1;
    localparam int          CYCLE_LIMIT = 100_000;
    localparam int          ITEM_TARGET = 2000;
    localparam logic        REQ_WRITE   = 1'b0;
    localparam logic        REQ_READ    = 1'b1;

    // Bus engine states, in the order the engine walks them.
    typedef enum logic [4:0] {
        S_IDLE, S_START_HI, S_START_LO, S_TX_LO, S_TX_HI, S_TX_END,
        S_ACK_SETUP, S_ACK_RISE, S_ACK_POLL, S_RX_LO, S_RX_HI, S_RX_END,
        S_NACK_LO, S_NACK_HI, S_STOP_LO, S_STOP_HI, S_WRITE_WAIT, S_DONE
    } bus_state_e;

    // Which byte of the transaction is on the wire.
    typedef enum logic [1:0] {
        STG_DEVICE_W, STG_MEM_ADDR, STG_DATA, STG_DEVICE_R
    } stage_e;

    // Ready patterns of the result receiver.
    typedef enum logic [1:0] {
        RX_ALWAYS, RX_COIN, RX_THIRD, RX_MOSTLY
    } rx_style_e;

    // Scoreboard: predicts the bus levels of every tick and checks them in order.
    class eeprom_bus_model;
        bus_state_e  state;
        stage_e      stage;
        logic [3:0]  bit_cnt;
        logic [31:0] delay_cnt;
        logic [7:0]  poll_cnt;
        logic [7:0]  tx_byte;
        logic [7:0]  rx_byte;
        logic [7:0]  held_addr;
        logic [7:0]  held_data;
        logic        held_read;
        logic        err_flag;
        logic [7:0]  tick_rate;
        logic [6:0]  dev_addr;
        logic [7:0]  poll_limit;
        logic [15:0] wait_units;
        iebm_res_t   levels_due[$];
        int          mismatches;
        int          n_ticks;

        function new();
            state      = S_IDLE;
            stage      = STG_DEVICE_W;
            bit_cnt    = '0;
            delay_cnt  = '0;
            poll_cnt   = '0;
            tx_byte    = '0;
            rx_byte    = '0;
            held_addr  = '0;
            held_data  = '0;
            held_read  = 1'b0;
            err_flag   = 1'b0;
            tick_rate  = TICKS_PER_US_RESET;
            dev_addr   = DEVICE_ADDR_RESET;
            poll_limit = ACK_POLL_LIM_RESET;
            wait_units = WRITE_WAIT_US_RESET;
            mismatches = 0;
            n_ticks    = 0;
        endfunction

        function void write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] value);
            case (idx)
                CFG_TICKS_PER_US:  tick_rate  = value[7:0];
                CFG_DEVICE_ADDR:   dev_addr   = value[6:0];
                CFG_ACK_POLL_LIM:  poll_limit = value[7:0];
                CFG_WRITE_WAIT_US: wait_units = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return levels_due.size();
        endfunction

        // Enter a timed state lasting the given number of microsecond units.
        function void arm(bus_state_e nxt, logic [15:0] units);
            logic [31:0] span;
            span      = 32'(units) * 32'(tick_rate);
            state     = nxt;
            delay_cnt = (span > DELAY_MAX) ? DELAY_MAX : span;
        endfunction

        function void load_byte(logic [7:0] value);
            tx_byte = value;
            bit_cnt = '0;
            arm(S_TX_LO, UNITS_TWO);
        endfunction

        // The slave acknowledged the byte just sent: move to the next step.
        function void on_ack();
            case (stage)
                STG_DEVICE_W:
                begin
                    stage = STG_MEM_ADDR;
                    load_byte(held_addr);
                end
                STG_MEM_ADDR:
                begin
                    if (!held_read)
                    begin
                        stage = STG_DATA;
                        load_byte(held_data);
                    end
                    else
                    begin
                        stage   = STG_DEVICE_R;
                        tx_byte = {dev_addr, 1'b1};
                        arm(S_START_HI, UNITS_FOUR);
                    end
                end
                STG_DEVICE_R:
                begin
                    bit_cnt = '0;
                    arm(S_RX_LO, UNITS_TWO);
                end
                default: arm(S_STOP_LO, UNITS_FOUR);
            endcase
        endfunction

        // The delay of the current timed state has run out.
        function void finish_phase(logic sda);
            case (state)
                S_START_HI: arm(S_START_LO, UNITS_FOUR);
                S_START_LO:
                begin
                    bit_cnt = '0;
                    arm(S_TX_LO, UNITS_TWO);
                end
                S_TX_LO: arm(S_TX_HI, UNITS_TWO);
                S_TX_HI: arm(S_TX_END, UNITS_TWO);
                S_TX_END:
                begin
                    tx_byte = tx_byte << 1;
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt >= 4'd8)
                    begin
                        poll_cnt = '0;
                        arm(S_ACK_SETUP, UNITS_ONE);
                    end
                    else
                        arm(S_TX_LO, UNITS_TWO);
                end
                S_ACK_SETUP: arm(S_ACK_RISE, UNITS_ONE);
                S_ACK_RISE:
                begin
                    state     = S_ACK_POLL;
                    delay_cnt = '0;
                end
                S_RX_LO: arm(S_RX_HI, UNITS_TWO);
                S_RX_HI:
                begin
                    rx_byte = {rx_byte[6:0], sda};
                    arm(S_RX_END, UNITS_ONE);
                end
                S_RX_END:
                begin
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt >= 4'd8)
                        arm(S_NACK_LO, UNITS_TWO);
                    else
                        arm(S_RX_LO, UNITS_TWO);
                end
                S_NACK_LO: arm(S_NACK_HI, UNITS_TWO);
                S_NACK_HI: arm(S_STOP_LO, UNITS_FOUR);
                S_STOP_LO: arm(S_STOP_HI, UNITS_FOUR);
                S_STOP_HI:
                begin
                    if (!held_read && !err_flag)
                        arm(S_WRITE_WAIT, wait_units);
                    else
                    begin
                        state     = S_DONE;
                        delay_cnt = '0;
                    end
                end
                S_WRITE_WAIT:
                begin
                    state     = S_DONE;
                    delay_cnt = '0;
                end
                default:
                begin
                    state     = S_IDLE;
                    delay_cnt = '0;
                end
            endcase
        endfunction

        // Record one accepted tick; returns 1 when it launched a transaction.
        function bit note_tick(iebm_req_t t);
            iebm_res_t lv;
            bit        took;
            took           = 1'b0;
            lv.scl_level   = 1'b1;
            lv.sda_level   = 1'b1;
            lv.sda_driving = 1'b1;
            lv.busy_res    = 1'b1;
            lv.done_res    = 1'b0;
            case (state)
                S_IDLE: lv.busy_res = 1'b0;
                S_START_LO: lv.sda_level = 1'b0;
                S_TX_LO, S_TX_END:
                begin
                    lv.scl_level = 1'b0;
                    lv.sda_level = tx_byte[7];
                end
                S_TX_HI: lv.sda_level = tx_byte[7];
                S_ACK_SETUP, S_RX_LO:
                begin
                    lv.scl_level   = 1'b0;
                    lv.sda_driving = 1'b0;
                end
                S_ACK_RISE, S_ACK_POLL, S_RX_HI, S_RX_END: lv.sda_driving = 1'b0;
                S_NACK_LO: lv.scl_level = 1'b0;
                S_STOP_LO:
                begin
                    lv.scl_level = 1'b0;
                    lv.sda_level = 1'b0;
                end
                S_DONE:
                begin
                    lv.busy_res = 1'b0;
                    lv.done_res = 1'b1;
                end
                default: ;
            endcase
            lv.read_byte = rx_byte;
            lv.ack_error = err_flag;
            levels_due.push_back(lv);
            n_ticks++;

            // Advance the engine by one tick.
            if (state == S_IDLE)
            begin
                if (t.req_valid)
                begin
                    held_read = (t.req_type == REQ_READ);
                    held_addr = t.mem_address;
                    held_data = t.write_data;
                    err_flag  = 1'b0;
                    if (held_read)
                        rx_byte = '0;
                    stage   = STG_DEVICE_W;
                    tx_byte = {dev_addr, 1'b0};
                    arm(S_START_HI, UNITS_FOUR);
                    took = 1'b1;
                end
            end
            else if (state == S_DONE)
            begin
                state     = S_IDLE;
                delay_cnt = '0;
            end
            else if (state == S_ACK_POLL)
            begin
                if (!t.sda_in)
                    on_ack();
                else if (poll_cnt >= poll_limit)
                begin
                    err_flag = 1'b1;
                    arm(S_STOP_LO, UNITS_FOUR);
                end
                else
                    poll_cnt = poll_cnt + 8'd1;
            end
            else if (delay_cnt > 32'd1)
                delay_cnt = delay_cnt - 32'd1;
            else
                finish_phase(t.sda_in);
            return took;
        endfunction

        function string fmt_levels(iebm_res_t r);
            return $sformatf("scl=%b sda=%b drv=%b busy=%b done=%b byte=%h err=%b",
                             r.scl_level, r.sda_level, r.sda_driving, r.busy_res,
                             r.done_res, r.read_byte, r.ack_error);
        endfunction

        // Compare one accepted result with the oldest prediction.
        function void check_result(iebm_res_t got);
            iebm_res_t want;
            string     bad;
            if (levels_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with no tick outstanding: %s", fmt_levels(got));
                return;
            end
            want = levels_due.pop_front();
            bad  = "";
            if (got.scl_level !== want.scl_level)     bad = {bad, " scl_level"};
            if (got.sda_level !== want.sda_level)     bad = {bad, " sda_level"};
            if (got.sda_driving !== want.sda_driving) bad = {bad, " sda_driving"};
            if (got.busy_res !== want.busy_res)       bad = {bad, " busy_res"};
            if (got.done_res !== want.done_res)       bad = {bad, " done_res"};
            if (got.read_byte !== want.read_byte)     bad = {bad, " read_byte"};
            if (got.ack_error !== want.ack_error)     bad = {bad, " ack_error"};
            if (bad != "")
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: mismatch in%s\n  expected %s\n  actual   %s",
                             bad, fmt_levels(want), fmt_levels(got));
            end
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    iebm_cfg_if cfg ();
    iebm_req_if req ();
    iebm_res_if res ();

    i2c_eeprom_byte_master_core #(
        .DELAY_COUNT_WIDTH(DELAY_W)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg.sink),
        .req   (req.sink),
        .res   (res.source)
    );

    eeprom_bus_model bus;

    // Sender pacing.
    int burst_left = 0;
    int gap_left   = 0;
    bit steady     = 1'b0;

    // Receiver pacing.
    int        hold_request = 0;
    int        hold_left    = 0;
    int        rx_mode_left = 0;
    int        rx_count     = 0;
    rx_style_e rx_mode      = RX_ALWAYS;

    int cycle_count = 0;

    always #6 clk = ~clk;

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result receiver: checks every transaction and stalls on its own pattern.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res.valid && res.ready)
                bus.check_result(res.data);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (rx_mode_left == 0)
            begin
                rx_mode      = rx_style_e'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(20, 200);
            end
            else
                rx_mode_left--;
            rx_count++;
            if (hold_left > 0)
            begin
                hold_left--;
                res.ready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_ALWAYS: res.ready <= 1'b1;
                    RX_COIN:   res.ready <= 1'($urandom_range(0, 1));
                    RX_THIRD:  res.ready <= (rx_count % 3 == 0);
                    default:   res.ready <= ($urandom_range(0, 6) != 0);
                endcase
            end
        end
    end

    // Level the model slave puts on SDA for the next tick.
    function automatic logic slave_sda(bit drop_en, stage_e drop_at);
        if (bus.state == S_ACK_POLL)
        begin
            if (drop_en && bus.stage == drop_at)
                return 1'b1;
            return ($urandom_range(0, 3) == 0);
        end
        return 1'($urandom_range(0, 1));
    endfunction

    // Feed ticks until one transaction has been launched and has run to idle.
    task automatic run_transaction(input logic kind, input logic [7:0] addr,
                                   input logic [7:0] data, input bit drop_en,
                                   input stage_e drop_at, input int lead_idle);
        bit        launched;
        bit        finished;
        bit        accepted;
        int        idle_left;
        iebm_req_t tick;
        launched  = 1'b0;
        finished  = 1'b0;
        idle_left = lead_idle;
        while (!finished)
        begin
            @(posedge clk);
            accepted = req.valid && req.ready;
            if (accepted)
            begin
                if (bus.note_tick(req.data))
                    launched = 1'b1;
                else if (launched && bus.state == S_IDLE)
                    finished = 1'b1;
            end
            if (finished)
                req.valid <= 1'b0;
            else if (accepted || !req.valid)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req.valid <= 1'b0;
                end
                else
                begin
                    tick.sda_in = slave_sda(drop_en, drop_at);
                    if (bus.state == S_IDLE && !launched && idle_left == 0)
                    begin
                        tick.req_valid   = 1'b1;
                        tick.req_type    = kind;
                        tick.mem_address = addr;
                        tick.write_data  = data;
                    end
                    else
                    begin
                        // Requests offered while busy must be ignored.
                        if (bus.state == S_IDLE && !launched)
                            idle_left--;
                        tick.req_valid   = (bus.state != S_IDLE) && ($urandom_range(0, 3) == 0);
                        tick.req_type    = 1'($urandom_range(0, 1));
                        tick.mem_address = 8'($urandom_range(0, 255));
                        tick.write_data  = 8'($urandom_range(0, 255));
                    end
                    req.valid <= 1'b1;
                    req.data  <= tick;
                    if (burst_left > 0)
                        burst_left--;
                    else if (!steady)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = $urandom_range(1, 8);
                    end
                end
            end
        end
    endtask

    task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] value);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!(cfg.valid && cfg.ready))
            @(posedge clk);
        bus.write_reg(idx, value);
        cfg.valid <= 1'b0;
    endtask

    // Hold the sender until every outstanding tick has been checked.
    task automatic drain();
        while (bus.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int n_trans;
        bus       = new();
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data  = '0;
        req.valid = 1'b0;
        req.data  = '0;
        res.ready = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: a read with the reset device address and poll limit at the fastest timing.
        write_reg(CFG_TICKS_PER_US, 16'd1);
        run_transaction(REQ_READ, 8'h00, 8'h00, 1'b0, STG_DEVICE_W, 2);

        // Lowest device address, shortest poll limit, no write wait.
        drain();
        write_reg(CFG_DEVICE_ADDR, 16'd0);
        write_reg(CFG_ACK_POLL_LIM, 16'd1);
        write_reg(CFG_WRITE_WAIT_US, 16'd0);
        run_transaction(REQ_WRITE, 8'hFF, 8'hFF, 1'b0, STG_DEVICE_W, 0);

        // Highest device address and longest poll limit; a missing ack on the device address.
        drain();
        write_reg(CFG_DEVICE_ADDR, 16'd127);
        write_reg(CFG_ACK_POLL_LIM, 16'd255);
        run_transaction(REQ_WRITE, 8'h00, 8'h00, 1'b1, STG_DEVICE_W, 0);

        // Shortest poll limit; a missing ack on the data byte and on the device read address.
        drain();
        write_reg(CFG_ACK_POLL_LIM, 16'd1);
        run_transaction(REQ_WRITE, 8'h55, 8'hAA, 1'b1, STG_DATA, 0);
        run_transaction(REQ_READ, 8'h01, 8'h00, 1'b1, STG_DEVICE_R, 0);

        // Random transactions under a new register setting every dozen.
        n_trans = 0;
        while (bus.n_ticks < ITEM_TARGET)
        begin
            if (n_trans % 12 == 0)
            begin
                drain();
                write_reg(CFG_TICKS_PER_US, ($urandom_range(0, 4) == 0) ?
                          16'($urandom_range(3, 4)) : 16'($urandom_range(1, 2)));
                write_reg(CFG_DEVICE_ADDR, 16'($urandom_range(0, 127)));
                write_reg(CFG_ACK_POLL_LIM, ($urandom_range(0, 1) == 0) ?
                          16'($urandom_range(1, 6)) : 16'($urandom_range(1, 255)));
                write_reg(CFG_WRITE_WAIT_US, 16'($urandom_range(0, 20)));
            end
            steady = ($urandom_range(0, 3) == 0);
            // Long receiver hold-off while the sender keeps going.
            if (n_trans == 0)
            begin
                steady       = 1'b1;
                hold_request = 400;
            end
            run_transaction(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0),
                            stage_e'($urandom_range(0, 3)), $urandom_range(0, 3));
            n_trans++;
        end

        drain();
        repeat (8) @(posedge clk);
        if (bus.mismatches == 0 && bus.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/iebm_pkg.sv
hw/rtl/iebm_if.sv
hw/rtl/iebm_engine.sv
hw/rtl/iebm_queue.sv
hw/rtl/i2c_eeprom_byte_master_core.sv
verif/testbench.sv
